/* src/vr_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vr_pkg
// Shared constants, status codes, side-band types and rounding helper for the
// vector refraction pipeline.
// ----------------------------------------------------------------------------
package vr_pkg;

  localparam int FRAC        = 14;
  localparam int IDX_FRAC    = 12;
  localparam int VEC_W       = 16;
  localparam int IDX_W       = 16;
  localparam int D_W         = FRAC + 1;
  localparam int DIV_STAGES  = IDX_W;
  localparam int SQRT_IN_W   = 2 * FRAC + 1;
  localparam int SQRT_STAGES = FRAC + 1;
  localparam int RW          = 40;
  localparam int LAT         = 9 + DIV_STAGES + SQRT_STAGES;

  localparam logic [D_W-1:0] ONE = D_W'(1) << FRAC;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_TIR  = 2'd1;
  localparam logic [1:0] ST_DIV0 = 2'd2;

  typedef struct packed {
    logic signed [VEC_W-1:0] inc_x;
    logic signed [VEC_W-1:0] inc_y;
    logic signed [VEC_W-1:0] inc_z;
    logic signed [VEC_W:0]   nrm_x;
    logic signed [VEC_W:0]   nrm_y;
    logic signed [VEC_W:0]   nrm_z;
    logic [D_W-1:0]          d;
    logic                    div0;
    logic                    sat;
  } side_a_t;

  typedef struct packed {
    logic signed [VEC_W-1:0] inc_x;
    logic signed [VEC_W-1:0] inc_y;
    logic signed [VEC_W-1:0] inc_z;
    logic signed [VEC_W:0]   nrm_x;
    logic signed [VEC_W:0]   nrm_y;
    logic signed [VEC_W:0]   nrm_z;
    logic [IDX_W-1:0]        n;
    logic [18:0]             ndr;
    logic                    div0;
    logic                    tir;
  } side_b_t;

  // round to nearest, ties away from zero
  function automatic logic signed [RW-1:0] rnd_shr(input logic signed [RW-1:0] v,
                                                   input int unsigned sh);
    logic signed [RW-1:0] half;
    logic signed [RW-1:0] neg;
    half = $signed({{(RW-1){1'b0}}, 1'b1}) <<< (sh - 1);
    neg  = $signed({{(RW-1){1'b0}}, v[RW-1]});
    return (v + half - neg) >>> sh;
  endfunction

endpackage

/* src/vr_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vr_if
// Ray input and refraction result channels, valid/ready handshake.
// ----------------------------------------------------------------------------
interface vr_in_if;
  logic                            valid;
  logic                            ready;
  logic signed [vr_pkg::VEC_W-1:0] incident_x;
  logic signed [vr_pkg::VEC_W-1:0] incident_y;
  logic signed [vr_pkg::VEC_W-1:0] incident_z;
  logic signed [vr_pkg::VEC_W-1:0] normal_x;
  logic signed [vr_pkg::VEC_W-1:0] normal_y;
  logic signed [vr_pkg::VEC_W-1:0] normal_z;
  logic [vr_pkg::IDX_W-1:0]        index_inside;
  logic [vr_pkg::IDX_W-1:0]        index_outside;

  modport source (output valid, incident_x, incident_y, incident_z, normal_x, normal_y,
                  normal_z, index_inside, index_outside, input ready);
  modport sink (input valid, incident_x, incident_y, incident_z, normal_x, normal_y,
                normal_z, index_inside, index_outside, output ready);
endinterface

interface vr_out_if;
  logic                            valid;
  logic                            ready;
  logic signed [vr_pkg::VEC_W-1:0] refracted_x;
  logic signed [vr_pkg::VEC_W-1:0] refracted_y;
  logic signed [vr_pkg::VEC_W-1:0] refracted_z;
  logic [1:0]                      status;

  modport source (output valid, refracted_x, refracted_y, refracted_z, status, input ready);
  modport sink (input valid, refracted_x, refracted_y, refracted_z, status, output ready);
endinterface

/* src/vector_refraction.sv */
`timescale 1ns / 1ps
// Stages: 16 divider and 15 square root stages plus 9 arithmetic stages lie
// between the input beat and the result beat.
// Throughput: one beat per cycle; the whole pipeline stalls only while the output
// register holds a beat that is not taken.
// Reset: synchronous active-low rst_n clears all stage valid bits.
// ----------------------------------------------------------------------------
// vector_refraction
// Snell's law refraction of a unit direction at a surface, fixed point.
// ----------------------------------------------------------------------------
module vector_refraction (
  input  logic        clk,
  input  logic        rst_n,
  vr_in_if.sink       in_ch,
  vr_out_if.source    out_ch
);

  localparam int LAT = vr_pkg::LAT;
  localparam int RW  = vr_pkg::RW;
  localparam int VW  = vr_pkg::VEC_W;

  logic           en;
  logic [LAT-1:0] vld_r;

  assign en          = !vld_r[LAT-1] || out_ch.ready;
  assign in_ch.ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[LAT-2:0], in_ch.valid};
    end
  end

  // stage 1: dot product terms
  logic signed [2*VW-1:0] px_r, py_r, pz_r;
  logic signed [VW-1:0]   ix_r, iy_r, iz_r, nx_r, ny_r, nz_r;
  logic [vr_pkg::IDX_W-1:0] ni_r, no_r;

  always_ff @(posedge clk) begin
    if (en) begin
      px_r <= in_ch.incident_x * in_ch.normal_x;
      py_r <= in_ch.incident_y * in_ch.normal_y;
      pz_r <= in_ch.incident_z * in_ch.normal_z;
      ix_r <= in_ch.incident_x;
      iy_r <= in_ch.incident_y;
      iz_r <= in_ch.incident_z;
      nx_r <= in_ch.normal_x;
      ny_r <= in_ch.normal_y;
      nz_r <= in_ch.normal_z;
      ni_r <= in_ch.index_inside;
      no_r <= in_ch.index_outside;
    end
  end

  // stage 2: side select, cosine, ratio operands
  logic signed [2*VW+1:0]   dot;
  logic                     front;
  logic [2*VW+1:0]          mag;
  logic signed [RW-1:0]     d_rnd;
  logic [vr_pkg::IDX_W-1:0] num, den;
  vr_pkg::side_a_t          sa_nxt, sa2_r;
  logic [vr_pkg::IDX_W-1:0] num_r, den_r;

  always_comb begin
    dot   = (2*VW+2)'(px_r) + (2*VW+2)'(py_r) + (2*VW+2)'(pz_r);
    front = dot[2*VW+1];
    mag   = front ? -dot : dot;
    d_rnd = vr_pkg::rnd_shr(RW'(mag), vr_pkg::FRAC);
    num   = front ? ni_r : no_r;
    den   = front ? no_r : ni_r;
    sa_nxt.inc_x = ix_r;
    sa_nxt.inc_y = iy_r;
    sa_nxt.inc_z = iz_r;
    sa_nxt.nrm_x = front ? (VW+1)'(nx_r) : -(VW+1)'(nx_r);
    sa_nxt.nrm_y = front ? (VW+1)'(ny_r) : -(VW+1)'(ny_r);
    sa_nxt.nrm_z = front ? (VW+1)'(nz_r) : -(VW+1)'(nz_r);
    sa_nxt.d     = (d_rnd > RW'(vr_pkg::ONE)) ? vr_pkg::ONE : d_rnd[vr_pkg::D_W-1:0];
    sa_nxt.div0  = den == '0;
    sa_nxt.sat   = {4'b0, num} >= {den, 4'b0};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sa2_r <= sa_nxt;
      num_r <= num;
      den_r <= den;
    end
  end

  // ratio divider with matching side delay
  logic [vr_pkg::IDX_W-1:0] q;
  vr_pkg::side_a_t          sa_dly_r [vr_pkg::DIV_STAGES];

  vr_div u_div (
    .clk (clk),
    .en  (en),
    .num (num_r),
    .den (den_r),
    .q   (q)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      sa_dly_r[0] <= sa2_r;
      for (int k = 1; k < vr_pkg::DIV_STAGES; k++) begin
        sa_dly_r[k] <= sa_dly_r[k-1];
      end
    end
  end

  // stage 19: squares and n*d
  vr_pkg::side_a_t          sa_q;
  logic [vr_pkg::IDX_W-1:0] n_sel;
  vr_pkg::side_b_t          sb19_r, sb20_r, sb21_r, sb22_r;
  logic [31:0]              nn_raw_r;
  logic [29:0]              d2_raw_r;
  logic [30:0]              nd_raw_r;

  assign sa_q  = sa_dly_r[vr_pkg::DIV_STAGES-1];
  assign n_sel = sa_q.sat ? '1 : q;

  always_ff @(posedge clk) begin
    if (en) begin
      sb19_r.inc_x <= sa_q.inc_x;
      sb19_r.inc_y <= sa_q.inc_y;
      sb19_r.inc_z <= sa_q.inc_z;
      sb19_r.nrm_x <= sa_q.nrm_x;
      sb19_r.nrm_y <= sa_q.nrm_y;
      sb19_r.nrm_z <= sa_q.nrm_z;
      sb19_r.n     <= n_sel;
      sb19_r.ndr   <= '0;
      sb19_r.div0  <= sa_q.div0;
      sb19_r.tir   <= 1'b0;
      nn_raw_r     <= 32'(n_sel) * 32'(n_sel);
      d2_raw_r     <= 30'(sa_q.d) * 30'(sa_q.d);
      nd_raw_r     <= 31'(n_sel) * 31'(sa_q.d);
    end
  end

  // stage 20: rounding
  logic signed [RW-1:0] nn_rnd, d2_rnd, nd_rnd;
  logic [20:0]          nn_r;
  logic [vr_pkg::D_W-1:0] omd_r;
  vr_pkg::side_b_t      sb20_nxt;

  assign nn_rnd = vr_pkg::rnd_shr(RW'(nn_raw_r), vr_pkg::IDX_FRAC);
  assign d2_rnd = vr_pkg::rnd_shr(RW'(d2_raw_r), vr_pkg::FRAC);
  assign nd_rnd = vr_pkg::rnd_shr(RW'(nd_raw_r), vr_pkg::IDX_FRAC);

  always_comb begin
    sb20_nxt     = sb19_r;
    sb20_nxt.ndr = nd_rnd[18:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sb20_r <= sb20_nxt;
      nn_r   <= nn_rnd[20:0];
      omd_r  <= vr_pkg::ONE - d2_rnd[vr_pkg::D_W-1:0];
    end
  end

  // stage 21: n^2 * (1 - d^2)
  logic [35:0] prod_raw_r;

  always_ff @(posedge clk) begin
    if (en) begin
      sb21_r     <= sb20_r;
      prod_raw_r <= 36'(nn_r) * 36'(omd_r);
    end
  end

  // stage 22: discriminant
  logic signed [RW-1:0] pr_rnd;
  logic signed [24:0]   det;
  logic [vr_pkg::SQRT_IN_W-1:0] sq_in_r;
  vr_pkg::side_b_t      sb22_nxt;

  assign pr_rnd = vr_pkg::rnd_shr(RW'(prod_raw_r), vr_pkg::IDX_FRAC);
  assign det    = $signed(25'(vr_pkg::ONE)) - $signed(pr_rnd[24:0]);

  always_comb begin
    sb22_nxt     = sb21_r;
    sb22_nxt.tir = det[24];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sb22_r  <= sb22_nxt;
      sq_in_r <= {det[vr_pkg::D_W-1:0], {vr_pkg::FRAC{1'b0}}};
    end
  end

  // square root with matching side delay
  logic [vr_pkg::SQRT_STAGES-1:0] s;
  vr_pkg::side_b_t                sb_dly_r [vr_pkg::SQRT_STAGES];

  vr_sqrt u_sqrt (
    .clk  (clk),
    .en   (en),
    .x    (sq_in_r),
    .root (s)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      sb_dly_r[0] <= sb22_r;
      for (int k = 1; k < vr_pkg::SQRT_STAGES; k++) begin
        sb_dly_r[k] <= sb_dly_r[k-1];
      end
    end
  end

  // stage 38: t = n*d - sqrt(det)
  vr_pkg::side_b_t    sb38_r, sb39_r;
  logic signed [19:0] t_r;

  always_ff @(posedge clk) begin
    if (en) begin
      sb38_r <= sb_dly_r[vr_pkg::SQRT_STAGES-1];
      t_r    <= $signed({1'b0, sb_dly_r[vr_pkg::SQRT_STAGES-1].ndr}) -
                $signed(20'(s));
    end
  end

  // stage 39: component products
  logic signed [32:0] ax_r, ay_r, az_r;
  logic signed [36:0] bx_r, by_r, bz_r;
  logic signed [16:0] n_s;

  assign n_s = $signed({1'b0, sb38_r.n});

  always_ff @(posedge clk) begin
    if (en) begin
      sb39_r <= sb38_r;
      ax_r   <= n_s * sb38_r.inc_x;
      ay_r   <= n_s * sb38_r.inc_y;
      az_r   <= n_s * sb38_r.inc_z;
      bx_r   <= sb38_r.nrm_x * t_r;
      by_r   <= sb38_r.nrm_y * t_r;
      bz_r   <= sb38_r.nrm_z * t_r;
    end
  end

  // stage 40: round, add, saturate into the output register
  function automatic logic signed [VW-1:0] comp(input logic signed [32:0] a,
                                                input logic signed [36:0] b);
    logic signed [RW-1:0] sum;
    sum = vr_pkg::rnd_shr(RW'(a), vr_pkg::IDX_FRAC) + vr_pkg::rnd_shr(RW'(b), vr_pkg::FRAC);
    if (sum > RW'(32767)) begin
      return 16'sh7FFF;
    end else if (sum < -RW'(32768)) begin
      return 16'sh8000;
    end
    return sum[VW-1:0];
  endfunction

  logic err;
  assign err = sb39_r.div0 || sb39_r.tir;

  always_ff @(posedge clk) begin
    if (en) begin
      out_ch.refracted_x <= err ? '0 : comp(ax_r, bx_r);
      out_ch.refracted_y <= err ? '0 : comp(ay_r, by_r);
      out_ch.refracted_z <= err ? '0 : comp(az_r, bz_r);
      out_ch.status      <= sb39_r.div0 ? vr_pkg::ST_DIV0 :
                            sb39_r.tir  ? vr_pkg::ST_TIR  : vr_pkg::ST_OK;
    end
  end

  assign out_ch.valid = vld_r[LAT-1];

endmodule

/* src/vr_div.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vr_div
// Pipelined restoring divider, one quotient bit per stage: (num << 12) / den.
// Valid only where the quotient fits 16 bits.
// ----------------------------------------------------------------------------
module vr_div (
  input  logic                       clk,
  input  logic                       en,
  input  logic [vr_pkg::IDX_W-1:0]   num,
  input  logic [vr_pkg::IDX_W-1:0]   den,
  output logic [vr_pkg::IDX_W-1:0]   q
);

  localparam int N = vr_pkg::DIV_STAGES;
  localparam int W = vr_pkg::IDX_W;

  logic [W:0]   rem_r [N];
  logic [W-1:0] low_r [N];
  logic [W-1:0] den_r [N];
  logic [W-1:0] q_r   [N];

  for (genvar k = 0; k < N; k++) begin : g_stage
    logic [W:0]   rem_prev;
    logic [W-1:0] low_prev;
    logic [W-1:0] den_prev;
    logic [W-1:0] q_prev;
    logic [W:0]   trial;
    logic         ge;

    if (k == 0) begin : g_first
      assign rem_prev = (W + 1)'(num[W-1:vr_pkg::IDX_W-vr_pkg::IDX_FRAC]);
      assign low_prev = {num[W-vr_pkg::IDX_FRAC-1:0], {vr_pkg::IDX_FRAC{1'b0}}};
      assign den_prev = den;
      assign q_prev   = '0;
    end else begin : g_rest
      assign rem_prev = rem_r[k-1];
      assign low_prev = low_r[k-1];
      assign den_prev = den_r[k-1];
      assign q_prev   = q_r[k-1];
    end

    assign trial = {rem_prev[W-1:0], low_prev[W-1]};
    assign ge    = trial >= {1'b0, den_prev};

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k] <= ge ? trial - {1'b0, den_prev} : trial;
        low_r[k] <= {low_prev[W-2:0], 1'b0};
        den_r[k] <= den_prev;
        q_r[k]   <= {q_prev[W-2:0], ge};
      end
    end
  end

  assign q = q_r[N-1];

endmodule

/* src/vr_sqrt.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vr_sqrt
// Pipelined integer square root, one root bit per stage, floor result.
// ----------------------------------------------------------------------------
module vr_sqrt (
  input  logic                           clk,
  input  logic                           en,
  input  logic [vr_pkg::SQRT_IN_W-1:0]   x,
  output logic [vr_pkg::SQRT_STAGES-1:0] root
);

  localparam int N  = vr_pkg::SQRT_STAGES;
  localparam int XW = vr_pkg::SQRT_IN_W;
  localparam int CW = XW + 2;

  logic [XW-1:0] rem_r  [N];
  logic [N-1:0]  root_r [N];

  for (genvar k = 0; k < N; k++) begin : g_stage
    localparam int I = N - 1 - k;
    logic [XW-1:0] rem_prev;
    logic [N-1:0]  root_prev;
    logic [CW-1:0] trial;
    logic          ge;

    if (k == 0) begin : g_first
      assign rem_prev  = x;
      assign root_prev = '0;
    end else begin : g_rest
      assign rem_prev  = rem_r[k-1];
      assign root_prev = root_r[k-1];
    end

    assign trial = (CW'(root_prev) << (I + 1)) + (CW'(1) << (2 * I));
    assign ge    = CW'(rem_prev) >= trial;

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k]  <= ge ? XW'(CW'(rem_prev) - trial) : rem_prev;
        root_r[k] <= ge ? (root_prev | (N'(1) << I)) : root_prev;
      end
    end
  end

  assign root = root_r[N-1];

endmodule

/* src/vr_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vr_checker
// Port-level checks for vector_refraction, bound to the top level.
// ----------------------------------------------------------------------------
module vr_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_valid,
  input logic                            in_ready,
  input logic                            out_valid,
  input logic                            out_ready,
  input logic signed [vr_pkg::VEC_W-1:0] out_x,
  input logic signed [vr_pkg::VEC_W-1:0] out_y,
  input logic signed [vr_pkg::VEC_W-1:0] out_z,
  input logic [1:0]                      out_status
);

  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result beat valid after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat dropped while stalled");

  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready == (!out_valid || out_ready))
    else $error("input ready does not follow output stall");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != vr_pkg::ST_OK |-> out_x == '0 && out_y == '0 && out_z == '0)
    else $error("error beat carries non-zero vector");

  a_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status == vr_pkg::ST_OK || out_status == vr_pkg::ST_TIR ||
                  out_status == vr_pkg::ST_DIV0)
    else $error("undefined status code");

  logic unused_in_valid;
  assign unused_in_valid = in_valid;

endmodule

bind vector_refraction vr_checker u_vr_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_ch.valid),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_x      (out_ch.refracted_x),
  .out_y      (out_ch.refracted_y),
  .out_z      (out_ch.refracted_z),
  .out_status (out_ch.status)
);

/* tb/sv/vector_refraction_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vector_refraction_tb
// Drives rays into the refraction pipeline under varied handshake pressure and
// checks every result beat against an in-bench fixed-point Snell's law model.
// ----------------------------------------------------------------------------
module vector_refraction_tb;

  typedef struct packed {
    logic signed [15:0] ix, iy, iz, nx, ny, nz;
    logic [15:0]        n_in, n_out;
  } ray_t;

  typedef struct packed {
    logic signed [15:0] rx, ry, rz;
    logic [1:0]         st;
  } refr_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  vr_in_if  in_ch ();
  vr_out_if out_ch ();

  vector_refraction uut (.clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch));

  always #1 clk = ~clk;

  refr_t expected_q[$];
  int    sent_cnt = 0;
  int    got_cnt = 0;
  int    err_cnt = 0;
  int    tir_cnt = 0;
  int    div0_cnt = 0;
  int    send_idle_pct = 0;
  int    recv_stall_pct = 0;
  int    hold_cycles = 0;

  function automatic longint round_shr(longint v, int s);
    longint half;
    half = longint'(1) << (s - 1);
    if (v < 0) return -((-v + half) >>> s);
    return (v + half) >>> s;
  endfunction

  function automatic longint root_floor(longint x);
    longint r, b;
    r = 0;
    b = longint'(1) << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic logic signed [15:0] clamp16(longint v);
    if (v > 32767) return 16'sh7FFF;
    if (v < -32768) return 16'sh8000;
    return v[15:0];
  endfunction

  function automatic refr_t refract(ray_t r);
    refr_t  o;
    longint inc[3], nrm[3], nm[3];
    longint dot, num, den, n, d, d2, nn, prod, det, s, t, a, b;
    longint one;
    one = longint'(1) << vr_pkg::FRAC;
    inc[0] = r.ix; inc[1] = r.iy; inc[2] = r.iz;
    nrm[0] = r.nx; nrm[1] = r.ny; nrm[2] = r.nz;
    dot = inc[0] * nrm[0] + inc[1] * nrm[1] + inc[2] * nrm[2];
    o = '0;
    if (dot < 0) begin
      for (int i = 0; i < 3; i++) nm[i] = nrm[i];
      num = r.n_in;
      den = r.n_out;
    end else begin
      for (int i = 0; i < 3; i++) nm[i] = -nrm[i];
      num = r.n_out;
      den = r.n_in;
    end
    if (den == 0) begin
      o.st = vr_pkg::ST_DIV0;
      return o;
    end
    n = (num << vr_pkg::IDX_FRAC) / den;
    if (n > 65535) n = 65535;
    d = round_shr(dot < 0 ? -dot : dot, vr_pkg::FRAC);
    if (d > one) d = one;
    d2 = round_shr(d * d, vr_pkg::FRAC);
    nn = round_shr(n * n, vr_pkg::IDX_FRAC);
    prod = round_shr(nn * (one - d2), vr_pkg::IDX_FRAC);
    det = one - prod;
    if (det < 0) begin
      o.st = vr_pkg::ST_TIR;
      return o;
    end
    s = root_floor(det << vr_pkg::FRAC);
    t = round_shr(n * d, vr_pkg::IDX_FRAC) - s;
    a = round_shr(n * inc[0], vr_pkg::IDX_FRAC); b = round_shr(nm[0] * t, vr_pkg::FRAC);
    o.rx = clamp16(a + b);
    a = round_shr(n * inc[1], vr_pkg::IDX_FRAC); b = round_shr(nm[1] * t, vr_pkg::FRAC);
    o.ry = clamp16(a + b);
    a = round_shr(n * inc[2], vr_pkg::IDX_FRAC); b = round_shr(nm[2] * t, vr_pkg::FRAC);
    o.rz = clamp16(a + b);
    o.st = vr_pkg::ST_OK;
    return o;
  endfunction

  initial begin
    in_ch.valid         = 1'b0;
    in_ch.incident_x    = '0;
    in_ch.incident_y    = '0;
    in_ch.incident_z    = '0;
    in_ch.normal_x      = '0;
    in_ch.normal_y      = '0;
    in_ch.normal_z      = '0;
    in_ch.index_inside  = '0;
    in_ch.index_outside = '0;
    out_ch.ready        = 1'b0;
  end

  task automatic send_ray(ray_t r);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.incident_x    <= r.ix;
    in_ch.incident_y    <= r.iy;
    in_ch.incident_z    <= r.iz;
    in_ch.normal_x      <= r.nx;
    in_ch.normal_y      <= r.ny;
    in_ch.normal_z      <= r.nz;
    in_ch.index_inside  <= r.n_in;
    in_ch.index_outside <= r.n_out;
    do @(posedge clk); while (!in_ch.ready);
    expected_q.push_back(refract(r));
    sent_cnt++;
  endtask

  // receiver: random stalls, or a counted hold-off when one is requested
  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    refr_t got, exp_r;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = {out_ch.refracted_x, out_ch.refracted_y, out_ch.refracted_z, out_ch.status};
      got_cnt++;
      if (expected_q.size() == 0) begin
        err_cnt++;
        if (err_cnt <= 10) $display("unexpected result beat %h", got);
      end else begin
        exp_r = expected_q.pop_front();
        if (got.st == vr_pkg::ST_TIR) tir_cnt++;
        if (got.st == vr_pkg::ST_DIV0) div0_cnt++;
        if (got !== exp_r) begin
          err_cnt++;
          if (err_cnt <= 10)
            $display({"mismatch beat %0d: exp x=%0d y=%0d z=%0d st=%0d",
                      " got x=%0d y=%0d z=%0d st=%0d"},
                     got_cnt, exp_r.rx, exp_r.ry, exp_r.rz, exp_r.st,
                     got.rx, got.ry, got.rz, got.st);
        end
      end
    end
  end

  function automatic ray_t unit_ray();
    ray_t r;
    int   a, b, c;
    real  m;
    a = $urandom_range(32766) - 16383; b = $urandom_range(32766) - 16383;
    c = $urandom_range(32766) - 16383;
    m = $sqrt(real'(a) * a + real'(b) * b + real'(c) * c) + 1.0;
    r.ix = 16'($rtoi(16384.0 * a / m)); r.iy = 16'($rtoi(16384.0 * b / m));
    r.iz = 16'($rtoi(16384.0 * c / m));
    a = $urandom_range(32766) - 16383; b = $urandom_range(32766) - 16383;
    c = $urandom_range(32766) - 16383;
    m = $sqrt(real'(a) * a + real'(b) * b + real'(c) * c) + 1.0;
    r.nx = 16'($rtoi(16384.0 * a / m)); r.ny = 16'($rtoi(16384.0 * b / m));
    r.nz = 16'($rtoi(16384.0 * c / m));
    r.n_in  = 16'(4096 + $urandom_range(6000));
    r.n_out = 16'(4096 + $urandom_range(6000));
    return r;
  endfunction

  function automatic ray_t any_ray();
    ray_t r;
    r = unit_ray();
    case ($urandom_range(9))
      0: r = {$urandom, $urandom, $urandom, $urandom};
      1: r.n_in = $urandom_range(1) ? 16'd0 : 16'($urandom);
      2: r.n_out = $urandom_range(1) ? 16'd0 : 16'($urandom);
      3: {r.ix, r.iy, r.iz} = 48'({$urandom, $urandom});
      default: ;
    endcase
    return r;
  endfunction

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (vr_pkg::LAT + 10) @(posedge clk);
  endtask

  task automatic test_directed();
    ray_t r;
    r = '{16'sd0, 16'sd0, -16'sd16384, 16'sd0, 16'sd0, 16'sd16384, 16'd4096, 16'd6144};
    send_ray(r);
    r.nz = -16'sd16384; send_ray(r);
    r = '{16'sd11585, 16'sd0, -16'sd11585, 16'sd0, 16'sd0, 16'sd16384, 16'd6144, 16'd4096};
    send_ray(r);
    r.n_in = 16'd65535; r.n_out = 16'd1; send_ray(r);
    r.n_out = 16'd0; send_ray(r);
    r.n_in = 16'd0; r.n_out = 16'd4096; r.nz = -16'sd16384; send_ray(r);
    r = '{16'sd16384, 16'sd0, 16'sd0, 16'sd0, 16'sd16384, 16'sd0, 16'd4096, 16'd5000};
    send_ray(r);
    r = '{16'sh8000, 16'sh8000, 16'sh8000, 16'sd32767, 16'sd32767, 16'sd32767,
          16'd65535, 16'd65535};
    send_ray(r);
    r = '{16'sd32767, 16'sd32767, 16'sd32767, 16'sh8000, 16'sh8000, 16'sh8000,
          16'd1, 16'd65535};
    send_ray(r);
    r = '{16'sd32767, 16'sh8000, 16'sd100, 16'sd0, 16'sd0, 16'sh8000, 16'd65535, 16'd1};
    send_ray(r);
    r = '0; send_ray(r);
    r = '1; send_ray(r);
    drain();
  endtask

  task automatic test_random(int cnt, int idle, int stall);
    send_idle_pct  = idle;
    recv_stall_pct = stall;
    for (int i = 0; i < cnt; i++) send_ray(any_ray());
    drain();
  endtask

  task automatic test_backpressure();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_cycles    = 3 * vr_pkg::LAT;
    for (int i = 0; i < 150; i++) send_ray(unit_ray());
    drain();
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random(300, 0, 0);
    test_random(300, 65, 0);
    test_random(300, 0, 65);
    test_random(300, 26, 26);
    test_backpressure();
    $display("%0d rays sent, %0d results checked (%0d TIR, %0d zero index)",
             sent_cnt, got_cnt, tir_cnt, div0_cnt);
    $display("phases: directed, free-flowing, sender idle, receiver stall, mixed, long hold-off");
    if (err_cnt == 0 && expected_q.size() == 0) begin
      $display("vector_refraction_tb: clean");
    end else begin
      $display("%0d mismatches, %0d beats missing", err_cnt, expected_q.size());
      $display("vector_refraction_tb: errors");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("timeout");
    $display("vector_refraction_tb: errors");
    $finish;
  end

endmodule

/* vector_refraction.f */
src/vr_pkg.sv
src/vr_if.sv
src/vr_div.sv
src/vr_sqrt.sv
src/vector_refraction.sv
src/vr_checker.sv
tb/sv/vector_refraction_tb.sv
